FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// Shared wrappers for the concurrent checks of the stencil block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge outside reset
`define FPS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every clock edge, reset included
`define FPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/fps_pkg.sv
// ----------------------------------------------------------------------------
// fps_pkg
// Types and constants shared by the five-point stencil stream modules.
// ----------------------------------------------------------------------------
package fps_pkg;

    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int ROW_WIDTH_BITS = 13;
    localparam int ROW_COUNT_BITS = 16;
    localparam int GAIN_BITS      = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int FRAC_BITS      = 8;

    localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RST     = 13'd4096;
    localparam logic [ROW_COUNT_BITS-1:0] ROW_COUNT_RST     = 16'd4096;
    localparam logic signed [GAIN_BITS-1:0] CENTER_GAIN_RST   = 16'sd512;
    localparam logic signed [GAIN_BITS-1:0] NEIGHBOR_GAIN_RST = 16'sd768;

    typedef enum logic [1:0] {
        REG_ROW_WIDTH,
        REG_ROW_COUNT,
        REG_CENTER_GAIN,
        REG_NEIGHBOR_GAIN
    } cfg_index_t;

    typedef struct packed {
        logic [ROW_WIDTH_BITS-1:0] row_width;
        logic [ROW_COUNT_BITS-1:0] row_count;
    } geom_t;

    typedef struct packed {
        logic valid;
        logic last;
    } beat_ctl_t;

endpackage

FILE: src/five_point_stencil_stream.sv
// ----------------------------------------------------------------------------
// five_point_stencil_stream
// Streams a grid in raster order and returns, for every interior point, the
// rounded, saturated value center_gain * center + neighbor_gain * (sum of the
// four neighbors) with Q8.8 gains; border points give no beat, and tlast marks
// the final interior result of a frame. One sample is taken per clock while
// s_tready is high: the two line stores are simple dual-port memories read
// ahead through registers for the next sample, and the middle-row window is
// a chain of two cells, so no loop limits the rate. A result passes two
// pipeline stages and then the output register; a stalled output still lets
// the input run until the pipeline fills. The line stores are not cleared after
// reset and need no clearing pass; entries are valid once their row passes.
// Configuration is written through cfg_wr_en / cfg_index / cfg_data while
// the stream is idle.
// ----------------------------------------------------------------------------
module five_point_stencil_stream #(
    parameter int MAX_WIDTH   = fps_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = fps_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // config write port
    input  logic                                  cfg_wr_en,
    input  fps_pkg::cfg_index_t                   cfg_index,
    input  logic [fps_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    // sample beats
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,  // sample
    // result beats
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,  // value
    output logic                                  m_tlast
);

    import fps_pkg::*;

    geom_t                         geom_reg, geom_next;
    logic signed [GAIN_BITS-1:0]   cgain_reg, cgain_next;
    logic signed [GAIN_BITS-1:0]   ngain_reg, ngain_next;

    logic                          accept;
    beat_ctl_t                     emit;
    logic signed [SAMPLE_BITS+1:0] nsum;
    logic signed [SAMPLE_BITS-1:0] center;
    logic signed [SAMPLE_BITS-1:0] out_value;

    always_comb begin
        geom_next  = geom_reg;
        cgain_next = cgain_reg;
        ngain_next = ngain_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROW_WIDTH: begin
                    geom_next.row_width = cfg_data[ROW_WIDTH_BITS-1:0];
                end
                REG_ROW_COUNT: begin
                    geom_next.row_count = cfg_data[ROW_COUNT_BITS-1:0];
                end
                REG_CENTER_GAIN: begin
                    cgain_next = cfg_data[GAIN_BITS-1:0];
                end
                REG_NEIGHBOR_GAIN: begin
                    ngain_next = cfg_data[GAIN_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geom_reg.row_width <= ROW_WIDTH_RST;
            geom_reg.row_count <= ROW_COUNT_RST;
            cgain_reg          <= CENTER_GAIN_RST;
            ngain_reg          <= NEIGHBOR_GAIN_RST;
        end else begin
            geom_reg  <= geom_next;
            cgain_reg <= cgain_next;
            ngain_reg <= ngain_next;
        end
    end

    assign accept = s_tvalid && s_tready;

    fps_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .sample   (s_tdata[SAMPLE_BITS-1:0]),
        .geom_cur (geom_reg),
        .geom_nxt (geom_next),
        .emit     (emit),
        .nsum     (nsum),
        .center   (center)
    );

    fps_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_ctl        (emit),
        .in_nsum       (nsum),
        .in_center     (center),
        .center_gain   (cgain_reg),
        .neighbor_gain (ngain_reg),
        .in_ready      (s_tready),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_value     (out_value),
        .out_last      (m_tlast)
    );

    always_comb begin
        m_tdata                  = '0;
        m_tdata[SAMPLE_BITS-1:0] = out_value;
    end

endmodule

FILE: src/fps_cell.sv
// ----------------------------------------------------------------------------
// fps_cell
// One window cell: holds a middle-row sample and hands it to the next cell.
// ----------------------------------------------------------------------------
module fps_cell #(
    parameter int SAMPLE_BITS = fps_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          restart,
    input  logic signed [SAMPLE_BITS-1:0] restart_val,
    input  logic signed [SAMPLE_BITS-1:0] shift_in,
    output logic signed [SAMPLE_BITS-1:0] tap
);

    logic signed [SAMPLE_BITS-1:0] hold_reg;

    // at the start of a row the cell shows its restart value instead
    assign tap = restart ? restart_val : hold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= '0;
        end else if (advance) begin
            hold_reg <= shift_in;
        end
    end

endmodule

FILE: src/fps_front.sv
// ----------------------------------------------------------------------------
// fps_front
// Raster position, line stores, window cells and neighbor sum of the stencil.
// ----------------------------------------------------------------------------
module fps_front #(
    parameter int MAX_WIDTH   = fps_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = fps_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic signed [SAMPLE_BITS-1:0]   sample,
    input  fps_pkg::geom_t                  geom_cur,
    input  fps_pkg::geom_t                  geom_nxt,
    output fps_pkg::beat_ctl_t              emit,
    output logic signed [SAMPLE_BITS+1:0]   nsum,
    output logic signed [SAMPLE_BITS-1:0]   center
);

    import fps_pkg::*;

    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = WW + 1;
    localparam int NW = SAMPLE_BITS + 2;
    localparam int RW = ROW_COUNT_BITS;

    typedef struct packed {
        logic [CW-1:0] col;
        logic [RW-1:0] row;
    } pos_t;

    function automatic logic [WW-1:0] clamp_w(input logic [ROW_WIDTH_BITS-1:0] raw);
        logic [WW-1:0] w;
        if (32'(raw) < 32'd3) begin
            w = WW'(3);
        end else if (32'(raw) > 32'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(raw);
        end
        return w;
    endfunction

    function automatic logic [RW-1:0] clamp_h(input logic [RW-1:0] raw);
        return (raw < RW'(3)) ? RW'(3) : raw;
    endfunction

    // position left by a geometry change is pulled back into the frame
    function automatic pos_t fix_pos(input pos_t p, input logic [WW-1:0] w,
                                     input logic [RW-1:0] h);
        pos_t        q;
        logic [RW:0] r1;
        q  = p;
        r1 = {1'b0, p.row};
        if (WW'(p.col) >= w) begin
            q.col = '0;
            r1    = r1 + (RW+1)'(1);
        end
        if (r1 >= {1'b0, h}) begin
            q.row = '0;
        end else begin
            q.row = r1[RW-1:0];
        end
        return q;
    endfunction

    function automatic pos_t step_pos(input pos_t p, input logic [WW-1:0] w,
                                      input logic [RW-1:0] h);
        pos_t        q;
        logic [PW-1:0] cn;
        logic [RW:0]   rn;
        cn = PW'(p.col) + PW'(1);
        rn = {1'b0, p.row} + (RW+1)'(1);
        q  = p;
        if (cn >= PW'(w)) begin
            q.col = '0;
            q.row = (rn >= {1'b0, h}) ? '0 : rn[RW-1:0];
        end else begin
            q.col = cn[CW-1:0];
        end
        return q;
    endfunction

    logic [WW-1:0] w_cur, w_nxt;
    logic [RW-1:0] h_cur, h_nxt;

    pos_t pos_reg, pos_next, pos_eff, pos_rd;

    logic signed [SAMPLE_BITS-1:0] older_mem  [MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] recent_mem [MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] older_rd_reg, recent_rd_reg;
    logic signed [SAMPLE_BITS-1:0] first_reg;

    logic [CW-1:0] c;
    logic [RW-1:0] r;
    logic [PW-1:0] c_p1, c_p2, rd_p1;
    logic [RW:0]   r_p1;
    logic          row_start;
    logic          interior;
    logic signed [SAMPLE_BITS-1:0] right_val, left_tap, center_tap;

    assign w_cur = clamp_w(geom_cur.row_width);
    assign w_nxt = clamp_w(geom_nxt.row_width);
    assign h_cur = clamp_h(geom_cur.row_count);
    assign h_nxt = clamp_h(geom_nxt.row_count);

    assign pos_eff  = fix_pos(pos_reg, w_cur, h_cur);
    assign pos_next = accept ? step_pos(pos_eff, w_cur, h_cur) : pos_reg;
    // stores are read ahead, through a register, for the position the next beat will have
    assign pos_rd   = fix_pos(pos_next, w_nxt, h_nxt);
    assign rd_p1    = PW'(pos_rd.col) + PW'(1);

    assign c    = pos_eff.col;
    assign r    = pos_eff.row;
    assign c_p1 = PW'(c) + PW'(1);
    assign c_p2 = PW'(c) + PW'(2);
    assign r_p1 = {1'b0, r} + (RW+1)'(1);

    assign row_start = (c == '0);
    assign right_val = (c_p1 < PW'(w_cur)) ? recent_rd_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            older_mem[c]  <= center_tap;
            recent_mem[c] <= sample;
        end
        older_rd_reg  <= older_mem[pos_rd.col];
        recent_rd_reg <= recent_mem[rd_p1[CW-1:0]];
    end

    // copy of the first entry of the recent row, needed at each row start
    always_ff @(posedge aclk) begin
        if (accept && row_start) begin
            first_reg <= sample;
        end
    end

    fps_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell_center (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (accept),
        .restart     (row_start),
        .restart_val (first_reg),
        .shift_in    (right_val),
        .tap         (center_tap)
    );

    fps_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell_left (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (accept),
        .restart     (row_start),
        .restart_val ('0),
        .shift_in    (center_tap),
        .tap         (left_tap)
    );

    assign interior = (r >= RW'(2)) && !row_start && (c_p2 <= PW'(w_cur));

    assign emit.valid = accept && interior;
    assign emit.last  = (r_p1 == {1'b0, h_cur}) && (c_p2 == PW'(w_cur));

    assign nsum   = NW'(older_rd_reg) + NW'(sample) + NW'(left_tap) + NW'(right_val);
    assign center = center_tap;

endmodule

FILE: src/fps_mac.sv
// ----------------------------------------------------------------------------
// fps_mac
// Weighted sum, rounding and saturation pipeline with the output register.
// ----------------------------------------------------------------------------
module fps_mac #(
    parameter int SAMPLE_BITS = fps_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  fps_pkg::beat_ctl_t                     in_ctl,
    input  logic signed [SAMPLE_BITS+1:0]          in_nsum,
    input  logic signed [SAMPLE_BITS-1:0]          in_center,
    input  logic signed [fps_pkg::GAIN_BITS-1:0]   center_gain,
    input  logic signed [fps_pkg::GAIN_BITS-1:0]   neighbor_gain,
    output logic                                   in_ready,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [SAMPLE_BITS-1:0]          out_value,
    output logic                                   out_last
);

    import fps_pkg::*;

    localparam int NW  = SAMPLE_BITS + 2;
    localparam int PCW = SAMPLE_BITS + GAIN_BITS;
    localparam int PNW = NW + GAIN_BITS;
    localparam int AW  = PNW + 1;
    localparam int VW  = AW - FRAC_BITS;

    localparam logic signed [AW-1:0] ROUND  = AW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [VW-1:0] SAT_HI =
        {{(VW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [VW-1:0] SAT_LO =
        {{(VW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    logic                    v0_reg, v1_reg, vout_reg;
    logic                    last0_reg, last1_reg, last_out_reg;
    logic signed [NW-1:0]    nsum0_reg;
    logic signed [SAMPLE_BITS-1:0] ctr0_reg;
    logic signed [PCW-1:0]   pc1_reg;
    logic signed [PNW-1:0]   pn1_reg;
    logic signed [SAMPLE_BITS-1:0] value_reg;

    logic free0, free1, free2;
    logic signed [PCW-1:0] pc_next;
    logic signed [PNW-1:0] pn_next;
    logic signed [AW-1:0]  acc;
    logic signed [VW-1:0]  scaled;
    logic signed [SAMPLE_BITS-1:0] sat;

    // a stage takes new data when it is empty or its content moves on
    assign free2    = !vout_reg || out_ready;
    assign free1    = !v1_reg || free2;
    assign free0    = !v0_reg || free1;
    assign in_ready = free0;

    assign pc_next = ctr0_reg * center_gain;
    assign pn_next = nsum0_reg * neighbor_gain;

    always_comb begin
        acc    = AW'(pc1_reg) + AW'(pn1_reg) + ROUND;
        scaled = acc[AW-1:FRAC_BITS];
        if (scaled > SAT_HI) begin
            sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (scaled < SAT_LO) begin
            sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            sat = scaled[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end else begin
            if (free0) begin
                v0_reg <= in_ctl.valid;
            end
            if (free1) begin
                v1_reg <= v0_reg;
            end
            if (free2) begin
                vout_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (free0 && in_ctl.valid) begin
            nsum0_reg <= in_nsum;
            ctr0_reg  <= in_center;
            last0_reg <= in_ctl.last;
        end
        if (free1 && v0_reg) begin
            pc1_reg   <= pc_next;
            pn1_reg   <= pn_next;
            last1_reg <= last0_reg;
        end
        if (free2 && v1_reg) begin
            value_reg    <= sat;
            last_out_reg <= last1_reg;
        end
    end

    assign out_valid = vout_reg;
    assign out_value = value_reg;
    assign out_last  = last_out_reg;

endmodule

FILE: src/fps_checker.sv
// ----------------------------------------------------------------------------
// fps_checker
// Port-level checks of the stencil stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fps_checker #(
    parameter int SAMPLE_BITS = fps_pkg::SAMPLE_BITS_DEF
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
    input logic                             m_tlast
);

    // a held result beat keeps its payload
    `FPS_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result beat changed while stalled")

    // input backpressure only ever comes from a stalled output
    `FPS_ASSERT(a_stall_cause, aclk, aresetn, !s_tready |-> m_tvalid && !m_tready, "input stalled without output backpressure")

    // nothing leaves the block on the first cycle out of reset
    `FPS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result beat right after reset")

endmodule

bind five_point_stencil_stream fps_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_fps_checker (.*);
